// ===== hdl/lut_weighted_image_remap_assert.svh =====
// Assertion macros used by the remap engine back end.
`ifndef LUT_WEIGHTED_IMAGE_REMAP_ASSERT_SVH
`define LUT_WEIGHTED_IMAGE_REMAP_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define LWR_ASSERT_HOLDS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Same-cycle implication.
`define LWR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== hdl/lwr_pkg.sv =====
// Types, constants and defaults shared by the remap engine.
package lwr_pkg;

  // Fixed field widths
  localparam int PIX_W      = 8;
  localparam int IDX_W      = 17;
  localparam int WGT_W      = 16;
  localparam int POS_W      = 9;
  localparam int NUM_TAPS   = 4;
  localparam int TAP_W      = 2;
  localparam int IN_ROWS_W  = 9;
  localparam int DIM_W      = 10;
  localparam int CFG_DATA_W = 10;
  localparam int CFG_IDX_W  = 2;

  // Register reset values
  localparam logic [IN_ROWS_W-1:0] RST_IN_ROWS  = IN_ROWS_W'(240);
  localparam logic [DIM_W-1:0]     RST_IN_COLS  = DIM_W'(320);
  localparam logic [DIM_W-1:0]     RST_MAP_ROWS = DIM_W'(240);
  localparam logic [DIM_W-1:0]     RST_MAP_COLS = DIM_W'(320);

  // Parameter defaults
  localparam int DEF_MAX_IN_ROWS      = 256;
  localparam int DEF_MAX_IN_COLS      = 512;
  localparam int DEF_MAX_MAP_DIM      = 512;
  localparam int DEF_WEIGHT_FRAC_BITS = 15;

  // Queue depths (at least two)
  localparam int IN_Q_DEPTH  = 2;
  localparam int OUT_Q_DEPTH = 2;
  localparam int OUT_LVL_W   = $clog2(OUT_Q_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_ROWS  = 2'd0,
    REG_IN_COLS  = 2'd1,
    REG_MAP_ROWS = 2'd2,
    REG_MAP_COLS = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_MAP  = 1'b1
  } item_kind_e;

  typedef enum logic {
    BK_IDLE,
    BK_TAPS
  } back_state_e;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [NUM_TAPS-1:0][IDX_W-1:0] src_index;
    logic [NUM_TAPS-1:0][WGT_W-1:0] weight;
  } tap_set_t;

  typedef struct packed {
    tap_set_t         taps;
    logic [POS_W-1:0] out_row;
    logic [POS_W-1:0] out_col;
    logic             last;
  } map_item_t;

  typedef struct packed {
    logic [POS_W-1:0] out_row;
    logic [POS_W-1:0] out_col;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
    logic             last;
  } result_t;

endpackage

// ===== hdl/lut_weighted_image_remap.sv =====
// Remap engine top level: queue-style ports, front end, command queue, back end, result queue.
//
// Load items (kind 0) write one BGR pixel into the frame store at the column-major
// address col*in_rows+row and produce no result; the back end retires one load per
// cycle while no table entry is in progress. Map items (kind 1) read their four taps
// one after another from the single port of the frame store, holding the back end
// until the last tap read is issued; the result enters the result queue as the last
// tap's data leaves the registered read. The frame store is 131072 x 24 bits at the
// default sizes and is not cleared: only entries written by loads may be referenced.
// Configuration registers are written through cfg_we_i, cfg_idx_i and cfg_data_i; the
// user must write them only while the block is idle, as the block does not enforce it.
module lut_weighted_image_remap import lwr_pkg::*; #(
  parameter int MAX_IN_ROWS      = DEF_MAX_IN_ROWS,
  parameter int MAX_IN_COLS      = DEF_MAX_IN_COLS,
  parameter int MAX_MAP_DIM      = DEF_MAX_MAP_DIM,
  parameter int WEIGHT_FRAC_BITS = DEF_WEIGHT_FRAC_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // input items
  input  logic                  push,
  output logic                  full,
  input  logic                  kind_i,
  input  logic [PIX_W-1:0]      blue_i,
  input  logic [PIX_W-1:0]      green_i,
  input  logic [PIX_W-1:0]      red_i,
  input  logic [IDX_W-1:0]      src_index_0_i,
  input  logic [IDX_W-1:0]      src_index_1_i,
  input  logic [IDX_W-1:0]      src_index_2_i,
  input  logic [IDX_W-1:0]      src_index_3_i,
  input  logic [WGT_W-1:0]      weight_0_i,
  input  logic [WGT_W-1:0]      weight_1_i,
  input  logic [WGT_W-1:0]      weight_2_i,
  input  logic [WGT_W-1:0]      weight_3_i,
  // results
  output logic                  empty,
  input  logic                  pop,
  output logic [POS_W-1:0]      out_row_o,
  output logic [POS_W-1:0]      out_col_o,
  output logic [PIX_W-1:0]      out_blue_o,
  output logic [PIX_W-1:0]      out_green_o,
  output logic [PIX_W-1:0]      out_red_o,
  output logic                  last_pixel_o
);

  localparam int ADDR_W = $clog2(MAX_IN_ROWS * MAX_IN_COLS);

  typedef struct packed {
    item_kind_e        kind;
    logic [ADDR_W-1:0] addr;
    pixel_t            pixel;
    map_item_t         map;
  } cmd_t;

  localparam int CMD_W = $bits(cmd_t);
  localparam int RES_W = $bits(result_t);

  pixel_t               in_pixel;
  tap_set_t             in_taps;
  cmd_t                 fe_cmd, hd_cmd;
  logic [CMD_W-1:0]     hd_raw;
  logic                 fe_push, cq_full, cq_empty, cq_pop;
  logic [RES_W-1:0]     rq_raw;
  result_t              be_res, rq_res;
  logic                 be_push;
  logic [OUT_LVL_W-1:0] rq_level;

  // Gather input fields
  always_comb begin
    in_pixel.blue  = blue_i;
    in_pixel.green = green_i;
    in_pixel.red   = red_i;
    in_taps.src_index[0] = src_index_0_i;
    in_taps.src_index[1] = src_index_1_i;
    in_taps.src_index[2] = src_index_2_i;
    in_taps.src_index[3] = src_index_3_i;
    in_taps.weight[0]    = weight_0_i;
    in_taps.weight[1]    = weight_1_i;
    in_taps.weight[2]    = weight_2_i;
    in_taps.weight[3]    = weight_3_i;
  end

  assign full = cq_full;

  lwr_front #(
    .MAX_IN_ROWS (MAX_IN_ROWS),
    .MAX_IN_COLS (MAX_IN_COLS),
    .MAX_MAP_DIM (MAX_MAP_DIM)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .push_i     (push),
    .kind_i     (item_kind_e'(kind_i)),
    .pixel_i    (in_pixel),
    .taps_i     (in_taps),
    .full_i     (cq_full),
    .q_push_o   (fe_push),
    .q_kind_o   (fe_cmd.kind),
    .q_addr_o   (fe_cmd.addr),
    .q_pixel_o  (fe_cmd.pixel),
    .q_map_o    (fe_cmd.map)
  );

  // Command queue between front and back
  lwr_queue #(
    .WIDTH (CMD_W),
    .DEPTH (IN_Q_DEPTH)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fe_push),
    .data_i  (fe_cmd),
    .full_o  (cq_full),
    .pop_i   (cq_pop),
    .data_o  (hd_raw),
    .empty_o (cq_empty),
    .level_o ()
  );

  assign hd_cmd = cmd_t'(hd_raw);

  lwr_back #(
    .MAX_IN_ROWS      (MAX_IN_ROWS),
    .MAX_IN_COLS      (MAX_IN_COLS),
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_empty_i   (cq_empty),
    .head_kind_i  (hd_cmd.kind),
    .head_addr_i  (hd_cmd.addr),
    .head_pixel_i (hd_cmd.pixel),
    .head_map_i   (hd_cmd.map),
    .in_pop_o     (cq_pop),
    .res_level_i  (rq_level),
    .res_push_o   (be_push),
    .res_o        (be_res)
  );

  // Result queue
  lwr_queue #(
    .WIDTH (RES_W),
    .DEPTH (OUT_Q_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (be_push),
    .data_i  (be_res),
    .full_o  (),
    .pop_i   (pop),
    .data_o  (rq_raw),
    .empty_o (empty),
    .level_o (rq_level)
  );

  assign rq_res       = result_t'(rq_raw);
  assign out_row_o    = rq_res.out_row;
  assign out_col_o    = rq_res.out_col;
  assign out_blue_o   = rq_res.blue;
  assign out_green_o  = rq_res.green;
  assign out_red_o    = rq_res.red;
  assign last_pixel_o = rq_res.last;

endmodule

// ===== hdl/lwr_queue.sv =====
// Small register FIFO used between the stages and on the result side.
module lwr_queue import lwr_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [WIDTH-1:0]             data_i,
  output logic                         full_o,
  input  logic                         pop_i,
  output logic [WIDTH-1:0]             data_o,
  output logic                         empty_o,
  output logic [$clog2(DEPTH+1)-1:0]   level_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign level_o = cnt_q;
  assign data_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== hdl/lwr_front.sv =====
// Front end: config registers, load and table position counters, item classification.
module lwr_front import lwr_pkg::*; #(
  parameter int MAX_IN_ROWS = DEF_MAX_IN_ROWS,
  parameter int MAX_IN_COLS = DEF_MAX_IN_COLS,
  parameter int MAX_MAP_DIM = DEF_MAX_MAP_DIM
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // incoming items
  input  logic                  push_i,
  input  item_kind_e            kind_i,
  input  pixel_t                pixel_i,
  input  tap_set_t              taps_i,
  // toward the command queue
  input  logic                  full_i,
  output logic                  q_push_o,
  output item_kind_e            q_kind_o,
  output logic [$clog2(MAX_IN_ROWS*MAX_IN_COLS)-1:0] q_addr_o,
  output pixel_t                q_pixel_o,
  output map_item_t             q_map_o
);

  localparam int ADDR_W = $clog2(MAX_IN_ROWS * MAX_IN_COLS);
  localparam int LR_W   = $clog2(MAX_IN_ROWS);
  localparam int LC_W   = $clog2(MAX_IN_COLS);
  localparam int MD_W   = $clog2(MAX_MAP_DIM);
  localparam int RD_W   = $clog2(MAX_IN_ROWS + 1);
  localparam int CD_W   = $clog2(MAX_IN_COLS + 1);
  localparam int TD_W   = $clog2(MAX_MAP_DIM + 1);
  localparam int PROD_W = LC_W + RD_W;

  function automatic logic [31:0] clamp_dim(input logic [31:0] v, input logic [31:0] hi);
    if (v == 32'd0) begin
      return 32'd1;
    end
    if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

  logic [IN_ROWS_W-1:0] in_rows_q;
  logic [DIM_W-1:0]     in_cols_q, map_rows_q, map_cols_q;
  logic [LR_W-1:0]      load_row_q, load_row_d, lr;
  logic [LC_W-1:0]      load_col_q, load_col_d, lc;
  logic [MD_W-1:0]      map_row_q, map_row_d, mr;
  logic [MD_W-1:0]      map_col_q, map_col_d, mc;
  logic [RD_W-1:0]      src_rows;
  logic [CD_W-1:0]      src_cols;
  logic [TD_W-1:0]      tbl_rows, tbl_cols;
  logic [PROD_W-1:0]    addr_full;
  logic [31:0]          lc_inc, lr_inc, mc_inc, mr_inc;
  logic                 accept;

  assign accept = push_i && !full_i;

  // Clamped dimensions
  assign src_rows = RD_W'(clamp_dim(32'(in_rows_q), 32'(MAX_IN_ROWS)));
  assign src_cols = CD_W'(clamp_dim(32'(in_cols_q), 32'(MAX_IN_COLS)));
  assign tbl_rows = TD_W'(clamp_dim(32'(map_rows_q), 32'(MAX_MAP_DIM)));
  assign tbl_cols = TD_W'(clamp_dim(32'(map_cols_q), 32'(MAX_MAP_DIM)));

  // Counters at or past their bound count as zero
  assign lr = (32'(load_row_q) >= 32'(src_rows)) ? '0 : load_row_q;
  assign lc = (32'(load_col_q) >= 32'(src_cols)) ? '0 : load_col_q;
  assign mr = (32'(map_row_q) >= 32'(tbl_rows)) ? '0 : map_row_q;
  assign mc = (32'(map_col_q) >= 32'(tbl_cols)) ? '0 : map_col_q;

  // Column-major store address of the current load
  assign addr_full = PROD_W'(lc) * PROD_W'(src_rows) + PROD_W'(lr);

  assign q_push_o  = accept;
  assign q_kind_o  = kind_i;
  assign q_addr_o  = ADDR_W'(addr_full);
  assign q_pixel_o = pixel_i;

  // Table entry: transposed, flipped output position and end-of-table flag
  always_comb begin
    q_map_o.taps    = taps_i;
    q_map_o.out_row = POS_W'(32'(tbl_cols) - 32'd1 - 32'(mc));
    q_map_o.out_col = POS_W'(mr);
    q_map_o.last    = (32'(mr) == 32'(tbl_rows) - 32'd1) &&
                      (32'(mc) == 32'(tbl_cols) - 32'd1);
  end

  // Position counter advance
  always_comb begin
    load_row_d = load_row_q;
    load_col_d = load_col_q;
    map_row_d  = map_row_q;
    map_col_d  = map_col_q;
    lc_inc     = 32'(lc) + 32'd1;
    lr_inc     = 32'(lr) + 32'd1;
    mc_inc     = 32'(mc) + 32'd1;
    mr_inc     = 32'(mr) + 32'd1;
    if (accept && (kind_i == KIND_LOAD)) begin
      if (lc_inc >= 32'(src_cols)) begin
        load_col_d = '0;
        load_row_d = (lr_inc >= 32'(src_rows)) ? '0 : LR_W'(lr_inc);
      end else begin
        load_col_d = LC_W'(lc_inc);
        load_row_d = lr;
      end
    end
    if (accept && (kind_i == KIND_MAP)) begin
      if (mc_inc >= 32'(tbl_cols)) begin
        map_col_d = '0;
        map_row_d = (mr_inc >= 32'(tbl_rows)) ? '0 : MD_W'(mr_inc);
      end else begin
        map_col_d = MD_W'(mc_inc);
        map_row_d = mr;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_row_q <= '0;
      load_col_q <= '0;
      map_row_q  <= '0;
      map_col_q  <= '0;
    end else begin
      load_row_q <= load_row_d;
      load_col_q <= load_col_d;
      map_row_q  <= map_row_d;
      map_col_q  <= map_col_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_rows_q  <= RST_IN_ROWS;
      in_cols_q  <= RST_IN_COLS;
      map_rows_q <= RST_MAP_ROWS;
      map_cols_q <= RST_MAP_COLS;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_IN_ROWS:  in_rows_q  <= cfg_data_i[IN_ROWS_W-1:0];
        REG_IN_COLS:  in_cols_q  <= cfg_data_i[DIM_W-1:0];
        REG_MAP_ROWS: map_rows_q <= cfg_data_i[DIM_W-1:0];
        REG_MAP_COLS: map_cols_q <= cfg_data_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/lwr_back.sv =====
// Back end: frame store, tap read sequencer and weighted accumulation.
`include "lut_weighted_image_remap_assert.svh"

module lwr_back import lwr_pkg::*; #(
  parameter int MAX_IN_ROWS      = DEF_MAX_IN_ROWS,
  parameter int MAX_IN_COLS      = DEF_MAX_IN_COLS,
  parameter int WEIGHT_FRAC_BITS = DEF_WEIGHT_FRAC_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // command queue head
  input  logic                  in_empty_i,
  input  item_kind_e            head_kind_i,
  input  logic [$clog2(MAX_IN_ROWS*MAX_IN_COLS)-1:0] head_addr_i,
  input  pixel_t                head_pixel_i,
  input  map_item_t             head_map_i,
  output logic                  in_pop_o,
  // result queue
  input  logic [OUT_LVL_W-1:0]  res_level_i,
  output logic                  res_push_o,
  output result_t               res_o
);

  localparam int FRAME_DEPTH = MAX_IN_ROWS * MAX_IN_COLS;
  localparam int ADDR_W      = $clog2(FRAME_DEPTH);
  localparam int PROD_W      = PIX_W + WGT_W;
  localparam int SUM_W       = PROD_W + 1;

  function automatic logic [PIX_W-1:0] tap_add(input logic [PIX_W-1:0] acc,
                                               input logic [PIX_W-1:0] pix,
                                               input logic [WGT_W-1:0] w);
    logic [PROD_W-1:0] prod;
    logic [SUM_W-1:0]  sum;
    prod = PROD_W'(pix) * PROD_W'(w);
    sum  = SUM_W'(prod >> WEIGHT_FRAC_BITS) + SUM_W'(acc);
    return (sum > SUM_W'({PIX_W{1'b1}})) ? {PIX_W{1'b1}} : PIX_W'(sum);
  endfunction

  back_state_e          state_q, state_d;
  logic [TAP_W-1:0]     iss_q, iss_d;
  logic [OUT_LVL_W-1:0] pend_q, pend_d;
  logic                 start_map, do_load, issue, credit_ok;
  logic [IDX_W-1:0]     cur_idx;
  logic [TAP_W-1:0]     cur_tap;
  logic [ADDR_W-1:0]    rd_addr;
  map_item_t            work_q;
  pixel_t               frame_mem [FRAME_DEPTH];
  pixel_t               rd_data_q, pix, acc_q, acc_base, acc_new;
  logic                 rd_vld_q, rd_oob_q;
  logic [TAP_W-1:0]     rd_tap_q;
  logic [WGT_W-1:0]     tap_w;

  // Room in the result queue for every entry already started
  assign credit_ok = (32'(res_level_i) + 32'(pend_q)) < 32'(OUT_Q_DEPTH);

  // Sequencer: one load per cycle while idle, or four tap reads per table entry
  always_comb begin
    state_d   = state_q;
    iss_d     = iss_q;
    start_map = 1'b0;
    do_load   = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (!in_empty_i) begin
          if (head_kind_i == KIND_MAP) begin
            if (credit_ok) begin
              start_map = 1'b1;
              state_d   = BK_TAPS;
              iss_d     = TAP_W'(1);
            end
          end else begin
            do_load = 1'b1;
          end
        end
      end
      BK_TAPS: begin
        iss_d = iss_q + TAP_W'(1);
        if (iss_q == TAP_W'(NUM_TAPS - 1)) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  assign in_pop_o = start_map || do_load;
  assign issue    = start_map || (state_q == BK_TAPS);
  assign cur_tap  = start_map ? '0 : iss_q;
  assign cur_idx  = start_map ? head_map_i.taps.src_index[0] : work_q.taps.src_index[iss_q];
  assign rd_addr  = ADDR_W'(32'(cur_idx));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BK_IDLE;
      iss_q    <= '0;
      pend_q   <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      iss_q    <= iss_d;
      pend_q   <= pend_d;
      rd_vld_q <= issue;
    end
  end

  // Entries started but not yet in the result queue
  always_comb begin
    pend_d = pend_q;
    if (start_map && !res_push_o) begin
      pend_d = pend_q + OUT_LVL_W'(1);
    end else if (res_push_o && !start_map) begin
      pend_d = pend_q - OUT_LVL_W'(1);
    end
  end

  // Working copy of the entry being processed
  always_ff @(posedge clk_i) begin
    if (start_map) begin
      work_q <= head_map_i;
    end
    if (issue) begin
      rd_tap_q <= cur_tap;
      rd_oob_q <= (32'(cur_idx) >= 32'(FRAME_DEPTH));
    end
  end

  // Single-port frame store, registered read
  always_ff @(posedge clk_i) begin
    if (do_load) begin
      frame_mem[head_addr_i] <= head_pixel_i;
    end else if (issue) begin
      rd_data_q <= frame_mem[rd_addr];
    end
  end

  // Accumulate one tap per cycle, saturating after each tap
  assign pix      = rd_oob_q ? '0 : rd_data_q;
  assign tap_w    = work_q.taps.weight[rd_tap_q];
  assign acc_base = (rd_tap_q == '0) ? '0 : acc_q;

  always_comb begin
    acc_new.blue  = tap_add(acc_base.blue,  pix.blue,  tap_w);
    acc_new.green = tap_add(acc_base.green, pix.green, tap_w);
    acc_new.red   = tap_add(acc_base.red,   pix.red,   tap_w);
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      acc_q <= acc_new;
    end
  end

  // Result after the last tap
  assign res_push_o = rd_vld_q && (rd_tap_q == TAP_W'(NUM_TAPS - 1));

  always_comb begin
    res_o.out_row = work_q.out_row;
    res_o.out_col = work_q.out_col;
    res_o.blue    = acc_new.blue;
    res_o.green   = acc_new.green;
    res_o.red     = acc_new.red;
    res_o.last    = work_q.last;
  end

  `LWR_ASSERT_HOLDS(a_res_credit, (32'(res_level_i) + 32'(pend_q)) <= 32'(OUT_Q_DEPTH),
                    "result queue overcommitted")
  `LWR_ASSERT_IMPL(a_res_latency, res_push_o,
                   $past(state_q == BK_TAPS) && ($past(iss_q) == TAP_W'(NUM_TAPS - 1)),
                   "result not right after the last tap read")
  `LWR_ASSERT_IMPL(a_tap_order, rd_vld_q && (rd_tap_q != '0),
                   $past(rd_vld_q) && (rd_tap_q == $past(rd_tap_q) + TAP_W'(1)),
                   "tap data out of order")

endmodule
